// ===== hw/rtl/vecalu_pkg.sv =====
// ----------------------------------------------------------------------------
// vecalu_pkg: shared types and constants of the homogeneous vector alu
// q16.16 word format, opcodes, payload words and the clamp / tolerance helpers
// ----------------------------------------------------------------------------
package vecalu_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int WORD_WIDTH = 32;

   localparam int OP_W    = 4;
   localparam int EPS_W   = 16;
   localparam int LANES   = 4;
   localparam int MUL_N   = 6;

   localparam int PROD_W    = 2 * WORD_WIDTH;
   localparam int FL_W      = PROD_W - FRAC_BITS;
   localparam int SUMSQ_W   = PROD_W + 1;
   localparam int ROOT_W    = WORD_WIDTH + 1;
   localparam int SQ_STEPS  = ROOT_W;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int SQ_REM_W  = ROOT_W + 3;
   localparam int NUM_W     = WORD_WIDTH + FRAC_BITS;
   localparam int DEN_W     = ROOT_W;
   localparam int DIV_STEPS = NUM_W;
   localparam int CLAMP_W   = 2 * WORD_WIDTH + 2;

   localparam logic [EPS_W-1:0] EPS_RESET = 16'd7;

   localparam logic [OP_W-1:0] OP_ADD       = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB       = 4'd1;
   localparam logic [OP_W-1:0] OP_SCALE     = 4'd2;
   localparam logic [OP_W-1:0] OP_NEGATE    = 4'd3;
   localparam logic [OP_W-1:0] OP_DIVIDE    = 4'd4;
   localparam logic [OP_W-1:0] OP_MAGNITUDE = 4'd5;
   localparam logic [OP_W-1:0] OP_DOT       = 4'd6;
   localparam logic [OP_W-1:0] OP_NORMALIZE = 4'd7;
   localparam logic [OP_W-1:0] OP_CROSS     = 4'd8;
   localparam logic [OP_W-1:0] OP_COMPARE   = 4'd9;
   localparam logic [OP_W-1:0] OP_CLASSIFY  = 4'd10;

   typedef logic signed [WORD_WIDTH-1:0] word_type;
   typedef logic signed [CLAMP_W-1:0]    wide_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
   localparam wide_type WIDE_MAX = wide_type'(WORD_MAX);
   localparam wide_type WIDE_MIN = wide_type'(WORD_MIN);
   localparam word_type ONE_FX   = word_type'(1 << FRAC_BITS);

   typedef struct packed {
      logic [OP_W-1:0] op;
      word_type        a_x;
      word_type        a_y;
      word_type        a_z;
      word_type        a_w;
      word_type        b_x;
      word_type        b_y;
      word_type        b_z;
      word_type        b_w;
      word_type        scalar;
   } req_word_type;

   typedef struct packed {
      word_type res_x;
      word_type res_y;
      word_type res_z;
      word_type res_w;
      word_type res_scalar;
      logic     equal_flag;
      logic     point_flag;
      logic     vector_flag;
      logic     div_zero;
      logic     saturated;
   } rsp_word_type;

   // item after the multiply / combine stages
   typedef struct packed {
      logic [OP_W-1:0]        op;
      word_type [LANES-1:0]   res;
      word_type               res_scalar;
      logic                   equal_flag;
      logic                   point_flag;
      logic                   vector_flag;
      logic                   saturated;
      word_type [LANES-1:0]   a;
      word_type               scalar;
      logic [SUMSQ_W-1:0]     sumsq;
   } mid_type;

   // item travelling alongside the divider lanes
   typedef struct packed {
      logic [OP_W-1:0]      op;
      word_type [LANES-1:0] res;
      word_type             res_scalar;
      logic                 equal_flag;
      logic                 point_flag;
      logic                 vector_flag;
      logic                 saturated;
      logic                 den_zero;
      logic [LANES-1:0]     q_neg;
      logic [LANES-1:0]     num_pos;
      logic [LANES-1:0]     num_neg;
      logic [DEN_W-1:0]     den;
   } carry_type;

   typedef struct packed {
      word_type value;
      logic     sat;
   } clamp_type;

   function automatic clamp_type clamp_word(input wide_type v);
      clamp_type c;
      c.value = word_type'(v);
      c.sat   = 1'b0;
      if (v > WIDE_MAX) begin
         c.value = WORD_MAX;
         c.sat   = 1'b1;
      end else if (v < WIDE_MIN) begin
         c.value = WORD_MIN;
         c.sat   = 1'b1;
      end
      return c;
   endfunction

   // |p - q| < eps
   function automatic logic near(input word_type p, input word_type q,
                                 input logic [EPS_W-1:0] eps);
      logic signed [WORD_WIDTH:0] d;
      logic [WORD_WIDTH:0]        m;
      d = {p[WORD_WIDTH-1], p} - {q[WORD_WIDTH-1], q};
      if (d < 0) begin
         m = -d;
      end else begin
         m = d;
      end
      return m < {{(WORD_WIDTH+1-EPS_W){1'b0}}, eps};
   endfunction

endpackage

// ===== hw/rtl/vector4_fixed_point_alu_top.sv =====
// ----------------------------------------------------------------------------
// vector4_fixed_point_alu_top: homogeneous 4d vector alu, signed q16.16
// add, sub, scale, negate, divide, magnitude, dot, normalise, cross,
// compare and classify on one request word, one response word per request
// ----------------------------------------------------------------------------
// usage
//   req channel: req_valid / req_stall / req_word, a word moves when
//     req_valid is high and req_stall low at a rising clock edge
//   rsp channel: rsp_valid / rsp_stall / rsp_word, same rule, the
//     receiver drives rsp_stall
//   csr channel: csr_valid / csr_ready / csr_data writes epsilon; csr_ready
//     is always high; the user writes only while no request is in flight, unchecked by the block
//   throughput: one word per cycle while req_stall is low, every opcode takes the same path
//   path: every word passes the multiply and combine registers, the
//     33-stage square root pipeline and the 48-stage divider pipeline,
//     then the output register
//   reset (synchronous): all stage valids and the output and skid valid flags
//     clear, epsilon returns to 7
//   rsp stall: one further finished word is caught in a skid register,
//     then req_stall rises and the whole pipeline holds; nothing is lost
// ----------------------------------------------------------------------------
module vector4_fixed_point_alu_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  vecalu_pkg::req_word_type      req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output vecalu_pkg::rsp_word_type      rsp_word,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [vecalu_pkg::EPS_W-1:0]  csr_data
);

   localparam int LN = vecalu_pkg::LANES;

   logic [vecalu_pkg::EPS_W-1:0]   epsilon_ff;

   // pipeline advance: everything moves unless the skid register is occupied
   logic                           adv;
   logic                           accept;

   logic                           mid_valid;
   vecalu_pkg::mid_type            mid_word;
   logic                           sq_valid;
   vecalu_pkg::mid_type            sq_word;
   logic [vecalu_pkg::ROOT_W-1:0]  sq_root;
   logic                           div_valid;
   vecalu_pkg::carry_type          div_carry;
   logic [LN-1:0][vecalu_pkg::NUM_W-1:0] div_quot;

   // final fix-up and output buffering
   vecalu_pkg::rsp_word_type       final_word;
   vecalu_pkg::word_type           res_l [LN];
   vecalu_pkg::wide_type           qw    [LN];
   vecalu_pkg::clamp_type          qc    [LN];
   logic                           sat_l;
   logic                           push;
   logic                           take;

   logic                           out_valid_ff;
   vecalu_pkg::rsp_word_type       out_word_ff;
   logic                           skid_full_ff;
   vecalu_pkg::rsp_word_type       skid_word_ff;

   // epsilon register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         epsilon_ff <= vecalu_pkg::EPS_RESET;
      end else if (csr_valid && csr_ready) begin
         epsilon_ff <= csr_data;
      end
   end

   assign adv       = ~skid_full_ff;
   assign req_stall = skid_full_ff;
   assign accept    = req_valid & ~req_stall;

   // multiply and combine
   vecalu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (accept),
      .in_word   (req_word),
      .epsilon   (epsilon_ff),
      .out_valid (mid_valid),
      .out_mid   (mid_word)
   );

   // magnitude for magnitude and normalise
   vecalu_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (mid_valid),
      .in_mid    (mid_word),
      .out_valid (sq_valid),
      .out_mid   (sq_word),
      .out_root  (sq_root)
   );

   // quotients for divide and normalise
   vecalu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .in_mid    (sq_word),
      .in_root   (sq_root),
      .out_valid (div_valid),
      .out_carry (div_carry),
      .out_quot  (div_quot)
   );

   // quotient sign, zero divisor handling and clamp
   always_comb begin
      sat_l = div_carry.saturated;
      final_word = '0;
      for (int i = 0; i < LN; i++) begin
         res_l[i] = div_carry.res[i];
         qw[i]    = vecalu_pkg::wide_type'(div_quot[i]);
         if (div_carry.q_neg[i]) begin
            qw[i] = -qw[i];
         end
         qc[i] = vecalu_pkg::clamp_word(qw[i]);
      end
      if ((div_carry.op == vecalu_pkg::OP_DIVIDE) ||
          (div_carry.op == vecalu_pkg::OP_NORMALIZE)) begin
         final_word.div_zero = div_carry.den_zero;
         for (int i = 0; i < LN; i++) begin
            if (div_carry.den_zero) begin
               // zero divisor: saturate towards the numerator's sign
               if (div_carry.num_pos[i]) begin
                  res_l[i] = vecalu_pkg::WORD_MAX;
                  sat_l    = 1'b1;
               end else if (div_carry.num_neg[i]) begin
                  res_l[i] = vecalu_pkg::WORD_MIN;
                  sat_l    = 1'b1;
               end else begin
                  res_l[i] = '0;
               end
            end else begin
               res_l[i] = qc[i].value;
               sat_l    = sat_l | qc[i].sat;
            end
         end
      end
      final_word.res_x       = res_l[0];
      final_word.res_y       = res_l[1];
      final_word.res_z       = res_l[2];
      final_word.res_w       = res_l[3];
      final_word.res_scalar  = div_carry.res_scalar;
      final_word.equal_flag  = div_carry.equal_flag;
      final_word.point_flag  = div_carry.point_flag;
      final_word.vector_flag = div_carry.vector_flag;
      final_word.saturated   = sat_l;
   end

   assign push = div_valid & adv;
   assign take = out_valid_ff & ~rsp_stall;

   // output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         if (out_valid_ff && !take) begin
            if (push) begin
               skid_full_ff <= 1'b1;
            end
         end else if (skid_full_ff) begin
            out_valid_ff <= 1'b1;
            skid_full_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid_ff && !take) begin
         if (push) begin
            skid_word_ff <= final_word;
         end
      end else if (skid_full_ff) begin
         out_word_ff <= skid_word_ff;
      end else if (push) begin
         out_word_ff <= final_word;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

`ifndef SYNTHESIS
   // skid entry only ever sits behind a waiting output word
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> out_valid_ff)
      else $error("skid register full with empty output register");

   // the skid entry is not dropped while the output word is not taken
   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff && !take |=> skid_full_ff)
      else $error("skid entry lost while output stalled");

   // compare gives no tuple and no saturation
   a_equal_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.equal_flag |->
         rsp_word.res_x == '0 && rsp_word.res_y == '0 &&
         rsp_word.res_z == '0 && rsp_word.res_w == '0 && !rsp_word.saturated)
      else $error("equal flag with non-zero result tuple");

   // zero divisor only comes from divide or normalise
   a_div_zero_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.div_zero |->
         rsp_word.res_scalar == '0 && !rsp_word.equal_flag &&
         !rsp_word.point_flag && !rsp_word.vector_flag)
      else $error("div zero flag mixed with other op results");
`endif

endmodule

// ===== hw/rtl/vecalu_front.sv =====
// ----------------------------------------------------------------------------
// vecalu_front: multiply and combine stages
// six shared multipliers, then floor shift, sums, clamps and tolerance tests
// ----------------------------------------------------------------------------
module vecalu_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  vecalu_pkg::req_word_type      in_word,
   input  logic [vecalu_pkg::EPS_W-1:0]  epsilon,
   output logic                          out_valid,
   output vecalu_pkg::mid_type           out_mid
);

   vecalu_pkg::word_type a_v [vecalu_pkg::LANES];
   vecalu_pkg::word_type b_v [vecalu_pkg::LANES];
   vecalu_pkg::word_type mul_a [vecalu_pkg::MUL_N];
   vecalu_pkg::word_type mul_b [vecalu_pkg::MUL_N];
   logic signed [vecalu_pkg::PROD_W-1:0] s1_prod_in [vecalu_pkg::MUL_N];

   logic                                 s1_valid_ff;
   vecalu_pkg::req_word_type             s1_word_ff;
   logic signed [vecalu_pkg::PROD_W-1:0] s1_prod_ff [vecalu_pkg::MUL_N];

   logic                                 s2_valid_ff;
   vecalu_pkg::mid_type                  s2_mid_ff;
   vecalu_pkg::mid_type                  s2_mid_in;

   vecalu_pkg::word_type                 a2 [vecalu_pkg::LANES];
   vecalu_pkg::word_type                 b2 [vecalu_pkg::LANES];
   logic signed [vecalu_pkg::FL_W-1:0]   fl [vecalu_pkg::MUL_N];
   vecalu_pkg::wide_type                 lane_v [vecalu_pkg::LANES];
   vecalu_pkg::wide_type                 dot_v;
   vecalu_pkg::clamp_type                lane_c [vecalu_pkg::LANES];
   vecalu_pkg::clamp_type                dot_c;

   // operand selection for the multipliers
   always_comb begin
      a_v[0] = in_word.a_x;
      a_v[1] = in_word.a_y;
      a_v[2] = in_word.a_z;
      a_v[3] = in_word.a_w;
      b_v[0] = in_word.b_x;
      b_v[1] = in_word.b_y;
      b_v[2] = in_word.b_z;
      b_v[3] = in_word.b_w;
      for (int i = 0; i < vecalu_pkg::LANES; i++) begin
         mul_a[i] = a_v[i];
         mul_b[i] = a_v[i];
      end
      mul_a[4] = '0;
      mul_b[4] = '0;
      mul_a[5] = '0;
      mul_b[5] = '0;
      unique case (in_word.op)
         vecalu_pkg::OP_SCALE: begin
            for (int i = 0; i < vecalu_pkg::LANES; i++) mul_b[i] = in_word.scalar;
         end
         vecalu_pkg::OP_DOT: begin
            for (int i = 0; i < vecalu_pkg::LANES; i++) mul_b[i] = b_v[i];
         end
         vecalu_pkg::OP_CROSS: begin
            mul_a[0] = a_v[1]; mul_b[0] = b_v[2];
            mul_a[1] = a_v[2]; mul_b[1] = b_v[1];
            mul_a[2] = a_v[2]; mul_b[2] = b_v[0];
            mul_a[3] = a_v[0]; mul_b[3] = b_v[2];
            mul_a[4] = a_v[0]; mul_b[4] = b_v[1];
            mul_a[5] = a_v[1]; mul_b[5] = b_v[0];
         end
         default: begin
         end
      endcase
      for (int i = 0; i < vecalu_pkg::MUL_N; i++) begin
         s1_prod_in[i] = $signed(mul_a[i]) * $signed(mul_b[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_word_ff <= in_word;
         s1_prod_ff <= s1_prod_in;
      end
   end

   // floor shift, sums and clamps
   always_comb begin
      a2[0] = s1_word_ff.a_x;
      a2[1] = s1_word_ff.a_y;
      a2[2] = s1_word_ff.a_z;
      a2[3] = s1_word_ff.a_w;
      b2[0] = s1_word_ff.b_x;
      b2[1] = s1_word_ff.b_y;
      b2[2] = s1_word_ff.b_z;
      b2[3] = s1_word_ff.b_w;
      for (int i = 0; i < vecalu_pkg::MUL_N; i++) begin
         fl[i] = s1_prod_ff[i][vecalu_pkg::PROD_W-1:vecalu_pkg::FRAC_BITS];
      end
      for (int i = 0; i < vecalu_pkg::LANES; i++) lane_v[i] = '0;
      dot_v = '0;
      unique case (s1_word_ff.op)
         vecalu_pkg::OP_ADD: begin
            for (int i = 0; i < vecalu_pkg::LANES; i++) begin
               lane_v[i] = vecalu_pkg::wide_type'(a2[i]) + vecalu_pkg::wide_type'(b2[i]);
            end
         end
         vecalu_pkg::OP_SUB: begin
            for (int i = 0; i < vecalu_pkg::LANES; i++) begin
               lane_v[i] = vecalu_pkg::wide_type'(a2[i]) - vecalu_pkg::wide_type'(b2[i]);
            end
         end
         vecalu_pkg::OP_SCALE: begin
            for (int i = 0; i < vecalu_pkg::LANES; i++) begin
               lane_v[i] = vecalu_pkg::wide_type'(fl[i]);
            end
         end
         vecalu_pkg::OP_NEGATE: begin
            for (int i = 0; i < vecalu_pkg::LANES; i++) begin
               lane_v[i] = -vecalu_pkg::wide_type'(a2[i]);
            end
         end
         vecalu_pkg::OP_DOT: begin
            dot_v = vecalu_pkg::wide_type'(fl[0]) + vecalu_pkg::wide_type'(fl[1])
                  + vecalu_pkg::wide_type'(fl[2]) + vecalu_pkg::wide_type'(fl[3]);
         end
         vecalu_pkg::OP_CROSS: begin
            lane_v[0] = vecalu_pkg::wide_type'(fl[0]) - vecalu_pkg::wide_type'(fl[1]);
            lane_v[1] = vecalu_pkg::wide_type'(fl[2]) - vecalu_pkg::wide_type'(fl[3]);
            lane_v[2] = vecalu_pkg::wide_type'(fl[4]) - vecalu_pkg::wide_type'(fl[5]);
         end
         default: begin
         end
      endcase

      s2_mid_in = '0;
      s2_mid_in.op = s1_word_ff.op;
      for (int i = 0; i < vecalu_pkg::LANES; i++) begin
         lane_c[i]           = vecalu_pkg::clamp_word(lane_v[i]);
         s2_mid_in.res[i]    = lane_c[i].value;
         s2_mid_in.a[i]      = a2[i];
      end
      dot_c                = vecalu_pkg::clamp_word(dot_v);
      s2_mid_in.res_scalar = dot_c.value;
      s2_mid_in.saturated  = dot_c.sat | lane_c[0].sat | lane_c[1].sat
                           | lane_c[2].sat | lane_c[3].sat;
      s2_mid_in.scalar     = s1_word_ff.scalar;
      // squares are never negative, so the raw products add as unsigned
      s2_mid_in.sumsq = {1'b0, s1_prod_ff[0]} + {1'b0, s1_prod_ff[1]}
                      + {1'b0, s1_prod_ff[2]} + {1'b0, s1_prod_ff[3]};
      if (s1_word_ff.op == vecalu_pkg::OP_COMPARE) begin
         s2_mid_in.equal_flag = vecalu_pkg::near(a2[0], b2[0], epsilon)
                              & vecalu_pkg::near(a2[1], b2[1], epsilon)
                              & vecalu_pkg::near(a2[2], b2[2], epsilon)
                              & vecalu_pkg::near(a2[3], b2[3], epsilon);
      end
      if (s1_word_ff.op == vecalu_pkg::OP_CLASSIFY) begin
         s2_mid_in.point_flag  = vecalu_pkg::near(a2[3], vecalu_pkg::ONE_FX, epsilon);
         s2_mid_in.vector_flag = vecalu_pkg::near(a2[3], '0, epsilon);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_mid_ff <= s2_mid_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_mid   = s2_mid_ff;

endmodule

// ===== hw/rtl/vecalu_sqrt.sv =====
// ----------------------------------------------------------------------------
// vecalu_sqrt: pipelined integer square root
// one root bit per stage over the sum of squares, item data carried alongside
// ----------------------------------------------------------------------------
module vecalu_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_valid,
   input  vecalu_pkg::mid_type             in_mid,
   output logic                            out_valid,
   output vecalu_pkg::mid_type             out_mid,
   output logic [vecalu_pkg::ROOT_W-1:0]   out_root
);

   logic                                valid_q [vecalu_pkg::SQ_STEPS+1];
   vecalu_pkg::mid_type                 mid_q   [vecalu_pkg::SQ_STEPS+1];
   logic [vecalu_pkg::SQ_REM_W-1:0]     rem_q   [vecalu_pkg::SQ_STEPS+1];
   logic [vecalu_pkg::ROOT_W-1:0]       root_q  [vecalu_pkg::SQ_STEPS+1];
   logic [vecalu_pkg::RAD_W-1:0]        rad_q   [vecalu_pkg::SQ_STEPS+1];

   assign valid_q[0] = in_valid;
   assign mid_q[0]   = in_mid;
   assign rem_q[0]   = '0;
   assign root_q[0]  = '0;
   assign rad_q[0]   = {{(vecalu_pkg::RAD_W-vecalu_pkg::SUMSQ_W){1'b0}}, in_mid.sumsq};

   for (genvar k = 0; k < vecalu_pkg::SQ_STEPS; k++) begin : g_step
      logic                             valid_ff;
      vecalu_pkg::mid_type              mid_ff;
      logic [vecalu_pkg::SQ_REM_W-1:0]  rem_ff;
      logic [vecalu_pkg::SQ_REM_W-1:0]  rem_in;
      logic [vecalu_pkg::SQ_REM_W-1:0]  rem_sh;
      logic [vecalu_pkg::SQ_REM_W-1:0]  trial;
      logic [vecalu_pkg::ROOT_W-1:0]    root_ff;
      logic [vecalu_pkg::ROOT_W-1:0]    root_in;
      logic [vecalu_pkg::RAD_W-1:0]     rad_ff;
      logic [vecalu_pkg::RAD_W-1:0]     rad_in;

      always_comb begin
         rem_sh = {rem_q[k][vecalu_pkg::SQ_REM_W-3:0], rad_q[k][vecalu_pkg::RAD_W-1 -: 2]};
         trial  = {{(vecalu_pkg::SQ_REM_W-vecalu_pkg::ROOT_W-2){1'b0}}, root_q[k], 2'b01};
         rad_in = {rad_q[k][vecalu_pkg::RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_q[k][vecalu_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_q[k][vecalu_pkg::ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (adv) begin
            valid_ff <= valid_q[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            mid_ff  <= mid_q[k];
            rem_ff  <= rem_in;
            root_ff <= root_in;
            rad_ff  <= rad_in;
         end
      end

      assign valid_q[k+1] = valid_ff;
      assign mid_q[k+1]   = mid_ff;
      assign rem_q[k+1]   = rem_ff;
      assign root_q[k+1]  = root_ff;
      assign rad_q[k+1]   = rad_ff;
   end

   assign out_valid = valid_q[vecalu_pkg::SQ_STEPS];
   assign out_mid   = mid_q[vecalu_pkg::SQ_STEPS];
   assign out_root  = root_q[vecalu_pkg::SQ_STEPS];

endmodule

// ===== hw/rtl/vecalu_div.sv =====
// ----------------------------------------------------------------------------
// vecalu_div: four-lane pipelined restoring divider
// divisor setup for divide / normalise, then one quotient bit per stage
// ----------------------------------------------------------------------------
module vecalu_div (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              adv,
   input  logic                                              in_valid,
   input  vecalu_pkg::mid_type                               in_mid,
   input  logic [vecalu_pkg::ROOT_W-1:0]                     in_root,
   output logic                                              out_valid,
   output vecalu_pkg::carry_type                             out_carry,
   output logic [vecalu_pkg::LANES-1:0][vecalu_pkg::NUM_W-1:0] out_quot
);

   localparam int LN = vecalu_pkg::LANES;
   localparam int NW = vecalu_pkg::NUM_W;
   localparam int DW = vecalu_pkg::DEN_W;
   localparam int WW = vecalu_pkg::WORD_WIDTH;
   localparam int FB = vecalu_pkg::FRAC_BITS;

   vecalu_pkg::carry_type           setup_c;
   vecalu_pkg::clamp_type           mag_c;
   logic [WW-1:0]                   abs_s;
   logic [WW-1:0]                   abs_a [LN];
   logic                            den_neg;
   logic [LN-1:0][NW-1:0]           num0;

   logic                            valid_q [vecalu_pkg::DIV_STEPS+1];
   vecalu_pkg::carry_type           carry_q [vecalu_pkg::DIV_STEPS+1];
   logic [LN-1:0][DW-1:0]           rem_q   [vecalu_pkg::DIV_STEPS+1];
   logic [LN-1:0][NW-1:0]           num_q   [vecalu_pkg::DIV_STEPS+1];

   // divisor, operand magnitudes and signs; magnitude result clamped here
   always_comb begin
      setup_c             = '0;
      setup_c.op          = in_mid.op;
      setup_c.res         = in_mid.res;
      setup_c.res_scalar  = in_mid.res_scalar;
      setup_c.equal_flag  = in_mid.equal_flag;
      setup_c.point_flag  = in_mid.point_flag;
      setup_c.vector_flag = in_mid.vector_flag;
      setup_c.saturated   = in_mid.saturated;
      mag_c = vecalu_pkg::clamp_word(vecalu_pkg::wide_type'(in_root));
      if (in_mid.op == vecalu_pkg::OP_MAGNITUDE) begin
         setup_c.res_scalar = mag_c.value;
         setup_c.saturated  = mag_c.sat;
      end
      abs_s = in_mid.scalar[WW-1] ? -in_mid.scalar : in_mid.scalar;
      if (in_mid.op == vecalu_pkg::OP_NORMALIZE) begin
         setup_c.den = in_root;
         den_neg     = 1'b0;
      end else begin
         setup_c.den = {1'b0, abs_s};
         den_neg     = in_mid.scalar[WW-1];
      end
      setup_c.den_zero = (setup_c.den == '0);
      for (int i = 0; i < LN; i++) begin
         abs_a[i] = in_mid.a[i][WW-1] ? -in_mid.a[i] : in_mid.a[i];
         num0[i]  = {abs_a[i], {FB{1'b0}}};
         setup_c.q_neg[i]   = in_mid.a[i][WW-1] ^ den_neg;
         setup_c.num_neg[i] = in_mid.a[i][WW-1];
         setup_c.num_pos[i] = ~in_mid.a[i][WW-1] & (in_mid.a[i] != '0);
      end
   end

   assign valid_q[0] = in_valid;
   assign carry_q[0] = setup_c;
   assign rem_q[0]   = '0;
   assign num_q[0]   = num0;

   for (genvar k = 0; k < vecalu_pkg::DIV_STEPS; k++) begin : g_step
      logic                   valid_ff;
      vecalu_pkg::carry_type  carry_ff;
      logic [LN-1:0][DW-1:0]  rem_ff;
      logic [LN-1:0][DW-1:0]  rem_in;
      logic [LN-1:0][NW-1:0]  num_ff;
      logic [LN-1:0][NW-1:0]  num_in;
      logic [DW:0]            rem_sh [LN];
      logic [DW:0]            diff   [LN];
      logic [DW:0]            den_x;

      always_comb begin
         den_x = {1'b0, carry_q[k].den};
         for (int i = 0; i < LN; i++) begin
            rem_sh[i] = {rem_q[k][i], num_q[k][i][NW-1]};
            diff[i]   = rem_sh[i] - den_x;
            if (rem_sh[i] >= den_x) begin
               rem_in[i] = diff[i][DW-1:0];
               num_in[i] = {num_q[k][i][NW-2:0], 1'b1};
            end else begin
               rem_in[i] = rem_sh[i][DW-1:0];
               num_in[i] = {num_q[k][i][NW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (adv) begin
            valid_ff <= valid_q[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            carry_ff <= carry_q[k];
            rem_ff   <= rem_in;
            num_ff   <= num_in;
         end
      end

      assign valid_q[k+1] = valid_ff;
      assign carry_q[k+1] = carry_ff;
      assign rem_q[k+1]   = rem_ff;
      assign num_q[k+1]   = num_ff;
   end

   assign out_valid = valid_q[vecalu_pkg::DIV_STEPS];
   assign out_carry = carry_q[vecalu_pkg::DIV_STEPS];
   assign out_quot  = num_q[vecalu_pkg::DIV_STEPS];

endmodule

// ===== verif/tb_vector4_fixed_point_alu_top.sv =====
// ----------------------------------------------------------------------------
// tb_vector4_fixed_point_alu_top: self-checking bench of the vector alu
// drives request words under several idle / stall mixes, predicts every
// response word in the bench and compares them field by field in order
// ----------------------------------------------------------------------------
module tb_vector4_fixed_point_alu_top;
   timeunit 1ns;
   timeprecision 1ps;

   import vecalu_pkg::*;

   localparam int LATENCY   = 83;
   localparam int WATCH_MAX = 20000;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_word_type         req_word = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_word_type         rsp_word;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [EPS_W-1:0]     csr_data = '0;

   // predicted responses, oldest first
   rsp_word_type         pending_rsp[$];
   logic [EPS_W-1:0]     tolerance;
   int                   error_count = 0;
   int                   quiet_cycles = 0;
   idle_mode_type        idle_mode = IDLE_NONE;
   bit                   hold_off = 1'b0;

   // directed rows, expected word only where it is obvious
   typedef struct {
      req_word_type  stim;
      bit            has_known;
      rsp_word_type  known;
   } dir_row_type;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   vector4_fixed_point_alu_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // ---- predictor ----

   function automatic longint clamp_to_word(input longint v, inout bit sat);
      longint hi;
      longint lo;
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (v > hi) begin
         sat = 1'b1;
         return hi;
      end
      if (v < lo) begin
         sat = 1'b1;
         return lo;
      end
      return v;
   endfunction

   // product floored by the fraction bits (>>> on longint is a floor)
   function automatic longint fix_product(input longint p, input longint q);
      longint m;
      m = p * q;
      return m >>> FRAC_BITS;
   endfunction

   function automatic longint fix_quotient(input longint num, input longint den,
                                           inout bit dz, inout bit sat);
      longint n;
      if (den == 0) begin
         dz = 1'b1;
         if (num > 0) begin
            sat = 1'b1;
            return 64'sd2147483647;
         end
         if (num < 0) begin
            sat = 1'b1;
            return -64'sd2147483648;
         end
         return 0;
      end
      n = num * 65536;
      return clamp_to_word(n / den, sat);
   endfunction

   function automatic longint tuple_length(input longint a[4]);
      logic [65:0] sum;
      logic [65:0] rem;
      logic [65:0] root;
      logic [65:0] bitv;
      longint      m;
      sum = '0;
      for (int i = 0; i < 4; i++) begin
         m = (a[i] < 0) ? -a[i] : a[i];
         sum += 66'(m) * 66'(m);
      end
      // bit-serial floor square root
      rem  = sum;
      root = '0;
      bitv = 66'd1 << 64;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem  = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv >>= 2;
      end
      return longint'(root);
   endfunction

   function automatic bit within_tol(input longint p, input longint q);
      longint d;
      d = p - q;
      if (d < 0) d = -d;
      return d < longint'(tolerance);
   endfunction

   function automatic rsp_word_type predict_alu(input req_word_type w);
      rsp_word_type r;
      longint a[4];
      longint b[4];
      longint v[4];
      longint s;
      longint acc;
      longint mag;
      bit     sat;
      bit     dz;
      bit     eq;
      a[0] = w.a_x; a[1] = w.a_y; a[2] = w.a_z; a[3] = w.a_w;
      b[0] = w.b_x; b[1] = w.b_y; b[2] = w.b_z; b[3] = w.b_w;
      s   = w.scalar;
      v   = '{0, 0, 0, 0};
      acc = 0;
      sat = 1'b0;
      dz  = 1'b0;
      r   = '0;
      case (w.op)
         OP_ADD:    for (int i = 0; i < 4; i++) v[i] = clamp_to_word(a[i] + b[i], sat);
         OP_SUB:    for (int i = 0; i < 4; i++) v[i] = clamp_to_word(a[i] - b[i], sat);
         OP_SCALE:
            for (int i = 0; i < 4; i++) v[i] = clamp_to_word(fix_product(a[i], s), sat);
         OP_NEGATE: for (int i = 0; i < 4; i++) v[i] = clamp_to_word(-a[i], sat);
         OP_DIVIDE:
            for (int i = 0; i < 4; i++) v[i] = fix_quotient(a[i], s, dz, sat);
         OP_MAGNITUDE: acc = clamp_to_word(tuple_length(a), sat);
         OP_DOT: begin
            for (int i = 0; i < 4; i++) acc += fix_product(a[i], b[i]);
            acc = clamp_to_word(acc, sat);
         end
         OP_NORMALIZE: begin
            mag = tuple_length(a);
            for (int i = 0; i < 4; i++) v[i] = fix_quotient(a[i], mag, dz, sat);
         end
         OP_CROSS: begin
            v[0] = clamp_to_word(fix_product(a[1], b[2]) - fix_product(a[2], b[1]), sat);
            v[1] = clamp_to_word(fix_product(a[2], b[0]) - fix_product(a[0], b[2]), sat);
            v[2] = clamp_to_word(fix_product(a[0], b[1]) - fix_product(a[1], b[0]), sat);
         end
         OP_COMPARE: begin
            eq = 1'b1;
            for (int i = 0; i < 4; i++) if (!within_tol(a[i], b[i])) eq = 1'b0;
            r.equal_flag = eq;
         end
         OP_CLASSIFY: begin
            r.point_flag  = within_tol(a[3], 65536);
            r.vector_flag = within_tol(a[3], 0);
         end
         default: ;
      endcase
      r.res_x      = word_type'(v[0]);
      r.res_y      = word_type'(v[1]);
      r.res_z      = word_type'(v[2]);
      r.res_w      = word_type'(v[3]);
      r.res_scalar = word_type'(acc);
      r.div_zero   = dz;
      r.saturated  = sat;
      return r;
   endfunction

   // ---- checking ----

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected word", 32'(rsp_word.res_x), 32'h0);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_word.res_x !== e.res_x) report_mismatch("res_x", rsp_word.res_x, e.res_x);
            if (rsp_word.res_y !== e.res_y) report_mismatch("res_y", rsp_word.res_y, e.res_y);
            if (rsp_word.res_z !== e.res_z) report_mismatch("res_z", rsp_word.res_z, e.res_z);
            if (rsp_word.res_w !== e.res_w) report_mismatch("res_w", rsp_word.res_w, e.res_w);
            if (rsp_word.res_scalar !== e.res_scalar)
               report_mismatch("res_scalar", rsp_word.res_scalar, e.res_scalar);
            if (rsp_word.equal_flag !== e.equal_flag)
               report_mismatch("equal_flag", 32'(rsp_word.equal_flag), 32'(e.equal_flag));
            if (rsp_word.point_flag !== e.point_flag)
               report_mismatch("point_flag", 32'(rsp_word.point_flag), 32'(e.point_flag));
            if (rsp_word.vector_flag !== e.vector_flag)
               report_mismatch("vector_flag", 32'(rsp_word.vector_flag), 32'(e.vector_flag));
            if (rsp_word.div_zero !== e.div_zero)
               report_mismatch("div_zero", 32'(rsp_word.div_zero), 32'(e.div_zero));
            if (rsp_word.saturated !== e.saturated)
               report_mismatch("saturated", 32'(rsp_word.saturated), 32'(e.saturated));
         end
      end
   end

   // receiver: random stall by phase, or a long hold-off on request
   always @(posedge clock) begin
      if (hold_off) begin
         rsp_stall <= 1'b1;
      end else if (idle_mode == IDLE_RECV) begin
         rsp_stall <= ($urandom_range(99) < 81);
      end else if (idle_mode == IDLE_BOTH) begin
         rsp_stall <= ($urandom_range(99) < 11);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCH_MAX) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // ---- stimulus ----

   function automatic word_type pick_component();
      case ($urandom_range(9))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return '0;
         3: return ONE_FX;
         4: return word_type'($urandom_range(15)) - 8;
         5: return word_type'($urandom);
         6: return word_type'(ONE_FX + $urandom_range(20) - 10);
         default: return word_type'($signed($urandom_range(32'h00FFFFFF)) - 32'sh007FFFFF);
      endcase
   endfunction

   function automatic req_word_type random_request();
      req_word_type w;
      w.op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 11)) : 4'($urandom_range(10));
      w.a_x = pick_component(); w.a_y = pick_component();
      w.a_z = pick_component(); w.a_w = pick_component();
      if (w.op == OP_COMPARE && $urandom_range(1)) begin
         // near copies so that equality is reached
         w.b_x = w.a_x + word_type'($urandom_range(16)) - 8;
         w.b_y = w.a_y + word_type'($urandom_range(16)) - 8;
         w.b_z = w.a_z + word_type'($urandom_range(16)) - 8;
         w.b_w = w.a_w + word_type'($urandom_range(16)) - 8;
      end else begin
         w.b_x = pick_component(); w.b_y = pick_component();
         w.b_z = pick_component(); w.b_w = pick_component();
      end
      w.scalar = pick_component();
      return w;
   endfunction

   // one word, prediction queued on the accepting edge
   task automatic send_word(input req_word_type w);
      int gap;
      gap = 0;
      if (idle_mode == IDLE_SEND) gap = ($urandom_range(99) < 81) ? $urandom_range(6, 1) : 0;
      if (idle_mode == IDLE_BOTH) gap = ($urandom_range(99) < 11) ? 1 : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.push_back(predict_alu(w));
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // epsilon only moves once the pipeline is empty
   task automatic write_tolerance(input logic [EPS_W-1:0] value);
      drain_pipe();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      tolerance = value;
   endtask

   function automatic req_word_type mk(input logic [OP_W-1:0] op, input word_type ax,
                                       input word_type ay, input word_type az,
                                       input word_type aw, input word_type bx,
                                       input word_type by, input word_type bz,
                                       input word_type bw, input word_type sc);
      req_word_type w;
      w = '{op, ax, ay, az, aw, bx, by, bz, bw, sc};
      return w;
   endfunction

   function automatic rsp_word_type flags(input word_type x, input word_type y,
                                          input word_type z, input word_type w,
                                          input word_type s, input logic [4:0] f);
      rsp_word_type r;
      r = '{x, y, z, w, s, f[4], f[3], f[2], f[1], f[0]};
      return r;
   endfunction

   initial begin
      dir_row_type  rows[$];
      dir_row_type  row;
      int           phase;
      word_type     big;
      word_type     low;
      big = WORD_MAX;
      low = WORD_MIN;
      tolerance = EPS_RESET;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; flags are equal, point, vector, div_zero, saturated
      rows.push_back('{mk(OP_ADD, big, 1, low, 0, 1, big, -1, 0, 0), 1'b1,
                       flags(big, big, low, 0, 0, 5'b00001)});
      rows.push_back('{mk(OP_SUB, low, 0, big, 5, 1, low, -1, 5, 0), 1'b1,
                       flags(low, big, big, 0, 0, 5'b00001)});
      rows.push_back('{mk(OP_NEGATE, low, big, 0, -1, 0, 0, 0, 0, 0), 1'b1,
                       flags(big, -big, 0, 1, 0, 5'b00001)});
      rows.push_back('{mk(OP_DIVIDE, 5, -5, 0, big, 0, 0, 0, 0, 0), 1'b1,
                       flags(big, low, 0, big, 0, 5'b00011)});
      rows.push_back('{mk(OP_NORMALIZE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                       flags(0, 0, 0, 0, 0, 5'b00010)});
      rows.push_back('{mk(OP_MAGNITUDE, low, low, low, low, 0, 0, 0, 0, 0), 1'b1,
                       flags(0, 0, 0, 0, big, 5'b00001)});
      rows.push_back('{mk(OP_CLASSIFY, 0, 0, 0, ONE_FX, 0, 0, 0, 0, 0), 1'b1,
                       flags(0, 0, 0, 0, 0, 5'b01000)});
      rows.push_back('{mk(OP_CLASSIFY, 0, 0, 0, 6, 0, 0, 0, 0, 0), 1'b1,
                       flags(0, 0, 0, 0, 0, 5'b00100)});
      rows.push_back('{mk(OP_CLASSIFY, 0, 0, 0, 7, 0, 0, 0, 0, 0), 1'b1,
                       flags(0, 0, 0, 0, 0, 5'b00000)});
      rows.push_back('{mk(OP_COMPARE, 1, 2, 3, 4, 7, 8, 9, 10, 0), 1'b1,
                       flags(0, 0, 0, 0, 0, 5'b10000)});
      rows.push_back('{mk(OP_COMPARE, 1, 2, 3, 4, 8, 2, 3, 4, 0), 1'b1,
                       flags(0, 0, 0, 0, 0, 5'b00000)});
      rows.push_back('{mk(4'd11, big, big, big, big, big, big, big, big, big), 1'b1, '0});
      rows.push_back('{mk(4'd15, low, low, low, low, low, low, low, low, low), 1'b1, '0});
      rows.push_back('{mk(OP_SCALE, big, low, ONE_FX, -1, 0, 0, 0, 0, big), 1'b0, '0});
      rows.push_back('{mk(OP_SCALE, -1, 3, -3, ONE_FX, 0, 0, 0, 0, -1), 1'b0, '0});
      rows.push_back('{mk(OP_DOT, big, big, big, big, big, big, big, big, 0), 1'b0, '0});
      rows.push_back('{mk(OP_DOT, low, 3, -3, 1, low, -1, -1, 1, 0), 1'b0, '0});
      rows.push_back('{mk(OP_CROSS, ONE_FX, 0, 0, 9, 0, ONE_FX, 0, 9, 0), 1'b0, '0});
      rows.push_back('{mk(OP_CROSS, low, big, low, 1, big, low, big, 1, 0), 1'b0, '0});
      rows.push_back('{mk(OP_DIVIDE, big, low, 1, -1, 0, 0, 0, 0, 1), 1'b0, '0});
      rows.push_back('{mk(OP_DIVIDE, -7, 7, big, low, 0, 0, 0, 0, -3), 1'b0, '0});
      rows.push_back('{mk(OP_NORMALIZE, 3 << 16, 4 << 16, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{mk(OP_MAGNITUDE, big, big, big, big, 0, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{mk(OP_NORMALIZE, low, 0, 0, 1, 0, 0, 0, 0, 0), 1'b0, '0});

      foreach (rows[i]) begin
         row = rows[i];
         if (row.has_known) begin
            if (predict_alu(row.stim) !== row.known)
               report_mismatch("directed row", i, 32'(row.known.res_x));
         end
         send_word(row.stim);
         if (row.has_known) begin
            // typed-in word replaces the prediction just queued
            void'(pending_rsp.pop_back());
            pending_rsp.push_back(row.known);
         end
      end
      drain_pipe();

      // random phases, the tolerance moves between them
      for (phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: write_tolerance(16'd0);
            1: write_tolerance(16'hFFFF);
            2: write_tolerance(16'd1);
            default: write_tolerance(16'($urandom));
         endcase
         idle_mode = idle_mode_type'(phase % 4);
         repeat (150) send_word(random_request());
         if (phase == 2) begin
            // sender waits for everything to come back before going on
            drain_pipe();
         end
         if (phase == 4) begin
            // long receiver hold-off while requests keep coming
            fork
               begin
                  hold_off = 1'b1;
                  repeat (300) @(posedge clock);
                  hold_off = 1'b0;
               end
               repeat (120) send_word(random_request());
            join
         end
      end
      write_tolerance(16'($urandom_range(30)));
      drain_pipe();

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
